/* sv/cso_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cso_pkg
// Types and constants shared by the candidate string odometer modules.
// ----------------------------------------------------------------------------
package cso_pkg;

	localparam int unsigned CHAR_W       = 8;
	localparam int unsigned POS_W        = 5;
	localparam int unsigned LEN_W        = 6;
	localparam int unsigned BASE_W       = 6;
	localparam int unsigned KIND_W       = 2;
	localparam int unsigned SEEK_W       = 64;
	localparam int unsigned RADIX_W      = CHAR_W + 1;
	localparam int unsigned RESULT_LIMIT = 32;

	// The seek divider retires this many quotient bits per cycle.
	localparam int unsigned DIV_STEP_BITS = 8;
	localparam int unsigned DIV_CYCLES    = SEEK_W / DIV_STEP_BITS;
	localparam int unsigned DIV_CNT_W     = $clog2(DIV_CYCLES);

	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	localparam logic [CHAR_W-1:0] RESET_CHAR      = 8'd32;
	localparam logic [CHAR_W-1:0] RESET_MIN_CHAR  = 8'd32;
	localparam logic [CHAR_W-1:0] RESET_MAX_CHAR  = 8'd126;
	localparam logic [BASE_W-1:0] RESET_START_LEN = 6'd1;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_NEXT  = 2'd1,
		KIND_SEEK  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_MIN_CHAR  = 2'd0,
		REG_MAX_CHAR  = 2'd1,
		REG_START_LEN = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'd0,
		ST_FILL      = 4'd1,
		ST_NEXT_RD   = 4'd2,
		ST_NEXT_CHK  = 4'd3,
		ST_NEXT_GROW = 4'd4,
		ST_DIV       = 4'd5,
		ST_SEEK_WR   = 4'd6,
		ST_EMIT_RD   = 4'd7,
		ST_EMIT_LD   = 4'd8
	} state_t;

	typedef enum logic [1:0] {
		WR_MIN   = 2'd0,
		WR_INC   = 2'd1,
		WR_DIGIT = 2'd2
	} wr_sel_t;

	typedef struct packed {
		logic    load;
		logic    idx_inc;
		logic    mem_wr;
		wr_sel_t wr_sel;
		logic    wr_at_len;
		logic    rd_idx;
		logic    rd_emit;
		logic    start_done;
		logic    grow;
		logic    set_ovf;
		logic    div_init;
		logic    div_step;
		logic    out_load;
	} cso_cmd_t;

	typedef struct packed {
		logic fill_done;
		logic rd_ge_top;
		logic idx_at_end;
		logic len_full;
		logic div_last;
		logic q_zero;
		logic out_free;
		logic emit_last;
	} cso_status_t;

endpackage

/* sv/cso_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cso_ifs
// Valid/ready channel interfaces for the item and result streams.
// ----------------------------------------------------------------------------
interface cso_item_if;
	logic                           valid;
	logic                           ready;
	logic [cso_pkg::KIND_W-1:0]     kind;
	logic [cso_pkg::SEEK_W-1:0]     seek_address;

	modport source(output valid, kind, seek_address, input ready);
	modport sink(input valid, kind, seek_address, output ready);
endinterface

interface cso_result_if;
	logic                           valid;
	logic                           ready;
	logic [cso_pkg::CHAR_W-1:0]     char_code;
	logic [cso_pkg::POS_W-1:0]      position;
	logic [cso_pkg::LEN_W-1:0]      length;
	logic                           overflow;
	logic                           last;

	modport source(output valid, char_code, position, length, overflow, last, input ready);
	modport sink(input valid, char_code, position, length, overflow, last, output ready);
endinterface

/* sv/cso_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cso_ctrl
// Sequencer that steps the datapath through start, next, seek and emission.
// ----------------------------------------------------------------------------
module cso_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  logic [cso_pkg::KIND_W-1:0] item_kind,
	output logic                       item_ready,
	input  cso_pkg::cso_status_t       status,
	output cso_pkg::cso_cmd_t          cmd
);

	cso_pkg::state_t state_q;
	cso_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cso_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			cso_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					case (cso_pkg::kind_t'(item_kind))
						cso_pkg::KIND_START: state_d = cso_pkg::ST_FILL;
						cso_pkg::KIND_NEXT:  state_d = cso_pkg::ST_NEXT_RD;
						cso_pkg::KIND_SEEK:  state_d = cso_pkg::ST_DIV;
						default:             state_d = cso_pkg::ST_EMIT_RD;
					endcase
				end
			end
			cso_pkg::ST_FILL: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_sel = cso_pkg::WR_MIN;
				if (status.fill_done) begin
					cmd.start_done = 1'b1;
					state_d        = cso_pkg::ST_EMIT_RD;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			cso_pkg::ST_NEXT_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = cso_pkg::ST_NEXT_CHK;
			end
			cso_pkg::ST_NEXT_CHK: begin
				cmd.mem_wr = 1'b1;
				if (status.rd_ge_top) begin
					cmd.wr_sel = cso_pkg::WR_MIN;
					if (status.idx_at_end) begin
						// Every position wrapped: the string grows at its left end, or overflows at full length.
						if (status.len_full) begin
							cmd.set_ovf = 1'b1;
							state_d     = cso_pkg::ST_EMIT_RD;
						end else begin
							state_d = cso_pkg::ST_NEXT_GROW;
						end
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = cso_pkg::ST_NEXT_RD;
					end
				end else begin
					cmd.wr_sel = cso_pkg::WR_INC;
					state_d    = cso_pkg::ST_EMIT_RD;
				end
			end
			cso_pkg::ST_NEXT_GROW: begin
				cmd.mem_wr    = 1'b1;
				cmd.wr_sel    = cso_pkg::WR_MIN;
				cmd.wr_at_len = 1'b1;
				cmd.grow      = 1'b1;
				state_d       = cso_pkg::ST_EMIT_RD;
			end
			cso_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = cso_pkg::ST_SEEK_WR;
				end
			end
			cso_pkg::ST_SEEK_WR: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_sel = cso_pkg::WR_DIGIT;
				if (status.idx_at_end && !status.q_zero) begin
					if (status.len_full) begin
						cmd.set_ovf = 1'b1;
						state_d     = cso_pkg::ST_EMIT_RD;
					end else begin
						cmd.grow     = 1'b1;
						cmd.idx_inc  = 1'b1;
						cmd.div_init = 1'b1;
						state_d      = cso_pkg::ST_DIV;
					end
				end else if (status.q_zero) begin
					state_d = cso_pkg::ST_EMIT_RD;
				end else begin
					cmd.idx_inc  = 1'b1;
					cmd.div_init = 1'b1;
					state_d      = cso_pkg::ST_DIV;
				end
			end
			cso_pkg::ST_EMIT_RD: begin
				cmd.rd_emit = 1'b1;
				state_d     = cso_pkg::ST_EMIT_LD;
			end
			cso_pkg::ST_EMIT_LD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = status.emit_last ? cso_pkg::ST_IDLE : cso_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = cso_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/cso_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cso_dpath
// Character store, length and overflow state, seek divider and result register.
// ----------------------------------------------------------------------------
module cso_dpath #(
	parameter int unsigned MAX_LEN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cso_pkg::cso_cmd_t           cmd,
	output cso_pkg::cso_status_t        status,
	input  logic [cso_pkg::CHAR_W-1:0]  min_char,
	input  logic [cso_pkg::CHAR_W-1:0]  max_char,
	input  logic [cso_pkg::BASE_W-1:0]  start_len,
	input  logic [cso_pkg::SEEK_W-1:0]  seek_address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cso_pkg::CHAR_W-1:0]  out_char_code,
	output logic [cso_pkg::POS_W-1:0]   out_position,
	output logic [cso_pkg::LEN_W-1:0]   out_length,
	output logic                        out_overflow,
	output logic                        out_last
);

	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned LW = $clog2(MAX_LEN + 1);
	localparam int unsigned CW = (LW > cso_pkg::LEN_W) ? LW : cso_pkg::LEN_W;

	// The store is kept right-aligned: address 0 holds the rightmost character,
	// so growing at the left only writes address current_length.
	logic [cso_pkg::CHAR_W-1:0] mem [MAX_LEN];
	logic [MAX_LEN-1:0]         vld_q;
	logic [cso_pkg::CHAR_W-1:0] rd_q;
	logic                       rd_vld_q;

	logic [LW-1:0]                   len_q;
	logic                            ovf_q;
	logic [LW-1:0]                   idx_q;
	logic [cso_pkg::POS_W-1:0]       k_q;
	logic [cso_pkg::SEEK_W-1:0]      q_q;
	logic [cso_pkg::CHAR_W-1:0]      rem_q;
	logic [cso_pkg::DIV_CNT_W-1:0]   dcnt_q;

	logic [cso_pkg::CHAR_W-1:0]  out_char_q;
	logic [cso_pkg::POS_W-1:0]   out_pos_q;
	logic [cso_pkg::LEN_W-1:0]   out_len_q;
	logic                        out_ovf_q;
	logic                        out_last_q;
	logic                        out_valid_q;

	logic [cso_pkg::CHAR_W-1:0]  eff_max;
	logic [cso_pkg::RADIX_W-1:0] radix;
	logic [CW-1:0]               base_ext;
	logic [CW-1:0]               base_c;
	logic [CW-1:0]               len_ext;
	logic [CW-1:0]               idx_ext;
	logic [CW-1:0]               emit_cnt;
	logic [CW-1:0]               emit_addr_ext;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic [cso_pkg::CHAR_W-1:0]  rd_eff;
	logic [cso_pkg::CHAR_W-1:0]  wr_data;
	logic                        emit_last;
	logic [cso_pkg::SEEK_W-1:0]  q_next;
	logic [cso_pkg::CHAR_W-1:0]  rem_next;

	// An inverted alphabet collapses to the single character min_char.
	assign eff_max  = (max_char < min_char) ? min_char : max_char;
	assign radix    = {1'b0, eff_max} - {1'b0, min_char} + 9'd1;
	assign base_ext = CW'(start_len);
	assign len_ext  = CW'(len_q);
	assign idx_ext  = CW'(idx_q);

	always_comb begin
		if (base_ext == '0) begin
			base_c = CW'(1);
		end else if (base_ext > CW'(MAX_LEN)) begin
			base_c = CW'(MAX_LEN);
		end else begin
			base_c = base_ext;
		end
	end

	assign emit_cnt      = (len_ext > CW'(cso_pkg::RESULT_LIMIT)) ?
	                       CW'(cso_pkg::RESULT_LIMIT) : len_ext;
	assign emit_last     = (CW'(k_q) + CW'(1)) == emit_cnt;
	assign emit_addr_ext = len_ext - CW'(1) - CW'(k_q);

	assign rd_addr = cmd.rd_emit ? emit_addr_ext[AW-1:0] : idx_q[AW-1:0];
	assign wr_addr = cmd.wr_at_len ? len_q[AW-1:0] : idx_q[AW-1:0];

	// Entries not written since reset still hold the reset character.
	assign rd_eff = rd_vld_q ? rd_q : cso_pkg::RESET_CHAR;

	always_comb begin
		case (cmd.wr_sel)
			cso_pkg::WR_MIN:   wr_data = min_char;
			cso_pkg::WR_INC:   wr_data = rd_eff + 8'd1;
			cso_pkg::WR_DIGIT: wr_data = rem_q + min_char;
			default:           wr_data = min_char;
		endcase
	end

	// Restoring division of the shift register by the radix, several quotient
	// bits per cycle; quotient bits enter at the bottom as dividend bits leave.
	always_comb begin
		logic [cso_pkg::RADIX_W-1:0] t;
		logic [cso_pkg::SEEK_W-1:0]  qq;
		logic [cso_pkg::CHAR_W-1:0]  r;
		qq = q_q;
		r  = rem_q;
		t  = '0;
		for (int s = 0; s < cso_pkg::DIV_STEP_BITS; s++) begin
			t  = {r, qq[cso_pkg::SEEK_W-1]};
			qq = {qq[cso_pkg::SEEK_W-2:0], 1'b0};
			if (t >= radix) begin
				t     = t - radix;
				qq[0] = 1'b1;
			end
			r = t[cso_pkg::CHAR_W-1:0];
		end
		q_next   = qq;
		rem_next = r;
	end

	assign status.fill_done  = (idx_ext + CW'(1)) == base_c;
	assign status.rd_ge_top  = rd_eff >= eff_max;
	assign status.idx_at_end = (idx_ext + CW'(1)) == len_ext;
	assign status.len_full   = len_ext >= CW'(MAX_LEN);
	assign status.div_last   = dcnt_q == cso_pkg::DIV_CNT_W'(cso_pkg::DIV_CYCLES - 1);
	assign status.q_zero     = q_q == '0;
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.emit_last  = emit_last;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_idx || cmd.rd_emit) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.mem_wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_idx || cmd.rd_emit) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LW'(1);
			ovf_q  <= 1'b0;
			idx_q  <= '0;
			k_q    <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.start_done) begin
				len_q <= base_c[LW-1:0];
				ovf_q <= 1'b0;
			end else if (cmd.grow) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + LW'(1);
			end
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.out_load) begin
				k_q <= k_q + 5'd1;
			end
			if (cmd.load || cmd.div_init) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + cso_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q   <= seek_address;
			rem_q <= '0;
		end else if (cmd.div_init) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			q_q   <= q_next;
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_char_q <= rd_eff;
			out_pos_q  <= k_q;
			out_len_q  <= len_ext[cso_pkg::LEN_W-1:0];
			out_ovf_q  <= ovf_q;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_char_code = out_char_q;
	assign out_position  = out_pos_q;
	assign out_length    = out_len_q;
	assign out_overflow  = out_ovf_q;
	assign out_last      = out_last_q;

`ifndef SYNTH
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before its transfer");

	a_grow_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grow |-> (len_ext < CW'(MAX_LEN)))
		else $error("string grown past its maximum length");

	a_remainder_in_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && status.div_last) |=> ({1'b0, rem_q} < radix))
		else $error("seek digit not below the radix");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_q && !cmd.start_done) |=> ovf_q)
		else $error("overflow flag cleared without a start item");
`endif

endmodule

/* sv/candidate_string_odometer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// candidate_string_odometer
// Holds a candidate string over the alphabet min_char..max_char. An item on
// the item channel starts it (kind 0), steps it like an odometer (kind 1) or
// seeks it to seek_address (kind 2); afterwards the whole string leaves on the
// result channel, one character per transfer, leftmost first, last on the
// final one (at most 32 transfers); any other kind only re-emits the string.
// Registers must be written over APB only while the block is idle; the block
// does not enforce this. A start fills each position of the start length, a
// next reads and rewrites each position it carries through (plus one write
// when it grows), a seek writes a digit per division pass (the divider retires
// eight quotient bits a cycle), and emission uses the single store read port.
// The item channel is ready again as soon as the last character has been
// loaded into the result register, which holds it while the receiver stalls;
// a stall on the result channel halts emission and nothing is lost.
// Reset returns the registers to 32, 126 and 1, the string to a single
// reset character and clears the overflow flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module candidate_string_odometer #(
	parameter int unsigned MAX_LEN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	cso_item_if.sink                    item,
	cso_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cso_pkg::APB_AW-1:0]  paddr,
	input  logic [cso_pkg::APB_DW-1:0]  pwdata,
	output logic [cso_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	logic [cso_pkg::CHAR_W-1:0] min_char_q;
	logic [cso_pkg::CHAR_W-1:0] max_char_q;
	logic [cso_pkg::BASE_W-1:0] start_len_q;
	logic                       cfg_wr;
	cso_pkg::reg_idx_t          reg_idx;

	cso_pkg::cso_cmd_t    cmd;
	cso_pkg::cso_status_t status;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = cso_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_char_q  <= cso_pkg::RESET_MIN_CHAR;
			max_char_q  <= cso_pkg::RESET_MAX_CHAR;
			start_len_q <= cso_pkg::RESET_START_LEN;
		end else if (cfg_wr) begin
			case (reg_idx)
				cso_pkg::REG_MIN_CHAR:  min_char_q  <= pwdata[cso_pkg::CHAR_W-1:0];
				cso_pkg::REG_MAX_CHAR:  max_char_q  <= pwdata[cso_pkg::CHAR_W-1:0];
				cso_pkg::REG_START_LEN: start_len_q <= pwdata[cso_pkg::BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cso_pkg::REG_MIN_CHAR:  prdata = cso_pkg::APB_DW'(min_char_q);
			cso_pkg::REG_MAX_CHAR:  prdata = cso_pkg::APB_DW'(max_char_q);
			cso_pkg::REG_START_LEN: prdata = cso_pkg::APB_DW'(start_len_q);
			default:                prdata = '0;
		endcase
	end

	cso_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_kind  (item.kind),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	cso_dpath #(
		.MAX_LEN (MAX_LEN)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.min_char      (min_char_q),
		.max_char      (max_char_q),
		.start_len     (start_len_q),
		.seek_address  (item.seek_address),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_char_code (result.char_code),
		.out_position  (result.position),
		.out_length    (result.length),
		.out_overflow  (result.overflow),
		.out_last      (result.last)
	);

endmodule

/* bench/candidate_string_odometer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// candidate_string_odometer_tb
// Self-checking bench for the candidate string odometer. A clocked driver
// sends start, next, seek and unknown-kind items from a queue. A clocked
// monitor checks every character transfer against a string predictor that
// runs when each item is accepted. The alphabet and base length are
// reprogrammed over APB between phases while the block is idle. Directed
// phases cover the extremes and corner cases first. Random phases follow,
// with varied alphabets and sender and receiver pacing.
// ----------------------------------------------------------------------------
module candidate_string_odometer_tb;

	localparam int unsigned STR_MAX      = 32;
	localparam int unsigned QUIET_LIMIT  = 8000;
	localparam int unsigned RAND_PHASES  = 8;
	localparam int unsigned PHASE_ITEMS  = 39;
	localparam logic [cso_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [cso_pkg::KIND_W-1:0] kind;
		logic [cso_pkg::SEEK_W-1:0] address;
		logic                       hold;
	} item_t;

	typedef struct packed {
		logic [cso_pkg::CHAR_W-1:0] char_code;
		logic [cso_pkg::POS_W-1:0]  position;
		logic [cso_pkg::LEN_W-1:0]  length;
		logic                       overflow;
		logic                       last;
	} char_beat_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [cso_pkg::APB_AW-1:0] paddr;
	logic [cso_pkg::APB_DW-1:0] pwdata;
	logic [cso_pkg::APB_DW-1:0] prdata;
	logic pready;

	cso_item_if   item_ch();
	cso_result_if result_ch();

	candidate_string_odometer #(.MAX_LEN(STR_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Predictor state and its copy of the registers.
	logic [cso_pkg::CHAR_W-1:0] cfg_min;
	logic [cso_pkg::CHAR_W-1:0] cfg_max;
	logic [cso_pkg::BASE_W-1:0] cfg_base;
	logic [cso_pkg::CHAR_W-1:0] string_chars [STR_MAX];
	int                         string_len;
	logic                       string_ovf;

	item_t      pending_items [$];
	char_beat_t expected_chars [$];
	item_t      cur_item;
	logic       all_settled;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         quiet_cycles;
	int         errors;
	int         n_start, n_next, n_seek, n_other;
	int         chars_checked;
	int         ovf_strings;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [cso_pkg::CHAR_W-1:0] alphabet_top();
		return (cfg_max < cfg_min) ? cfg_min : cfg_max;
	endfunction

	function automatic logic grow_at_left();
		int i;
		if (string_len >= STR_MAX) begin
			string_ovf = 1'b1;
			return 1'b0;
		end
		for (i = string_len; i > 0; i--)
			string_chars[i] = string_chars[i-1];
		string_chars[0] = cfg_min;
		string_len++;
		return 1'b1;
	endfunction

	function automatic void restart_string();
		int i;
		for (i = 0; i < STR_MAX; i++)
			string_chars[i] = cfg_min;
		if (cfg_base == 0)
			string_len = 1;
		else if (cfg_base > STR_MAX)
			string_len = STR_MAX;
		else
			string_len = cfg_base;
		string_ovf = 1'b0;
	endfunction

	function automatic void step_string();
		logic [cso_pkg::CHAR_W-1:0] top;
		int i;
		top = alphabet_top();
		i = string_len;
		while (i > 0) begin
			i--;
			if (string_chars[i] >= top) begin
				string_chars[i] = cfg_min;
				if (i == 0)
					void'(grow_at_left());
			end else begin
				string_chars[i] = string_chars[i] + 8'd1;
				break;
			end
		end
	endfunction

	function automatic void seek_string(input logic [cso_pkg::SEEK_W-1:0] address);
		logic [63:0] radix;
		logic [63:0] q;
		logic [63:0] digit;
		int          it;
		radix = 64'(alphabet_top()) - 64'(cfg_min) + 64'd1;
		q = address;
		it = 0;
		do begin
			digit = q % radix;
			q = q / radix;
			// Once the digits reach the left end the string must grow, and a
			// failed growth drops whatever digits remain.
			if (it + 1 == string_len && q > 0) begin
				if (!grow_at_left()) begin
					string_chars[string_len-it-1] = 8'(digit) + cfg_min;
					return;
				end
			end
			string_chars[string_len-it-1] = 8'(digit) + cfg_min;
			it++;
		end while (q > 0 && it < string_len);
	endfunction

	function automatic void advance_string(input item_t it);
		char_beat_t beat;
		int         k;
		case (it.kind)
			cso_pkg::KIND_START: restart_string();
			cso_pkg::KIND_NEXT:  step_string();
			cso_pkg::KIND_SEEK:  seek_string(it.address);
			default:             ;
		endcase
		for (k = 0; k < string_len && k < cso_pkg::RESULT_LIMIT; k++) begin
			beat.char_code = string_chars[k];
			beat.position  = cso_pkg::POS_W'(k);
			beat.length    = cso_pkg::LEN_W'(string_len);
			beat.overflow  = string_ovf;
			beat.last      = (k + 1 == string_len || k + 1 == cso_pkg::RESULT_LIMIT);
			expected_chars.push_back(beat);
		end
	endfunction

	function automatic void queue_item(input logic [cso_pkg::KIND_W-1:0] kind,
			input logic [cso_pkg::SEEK_W-1:0] address, input logic hold);
		item_t it;
		it.kind    = kind;
		it.address = address;
		it.hold    = hold;
		pending_items.push_back(it);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endfunction

	function automatic logic [cso_pkg::SEEK_W-1:0] pick_address(input int unsigned radix);
		case ($urandom_range(0, 4))
			0: return cso_pkg::SEEK_W'($urandom_range(0, radix * radix * radix));
			1: return cso_pkg::SEEK_W'($urandom);
			2: return {$urandom, $urandom};
			3: return {$urandom, $urandom} >> $urandom_range(0, 63);
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	task automatic apb_write(input cso_pkg::reg_idx_t idx,
			input logic [cso_pkg::APB_DW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic program_alphabet(input int lo, input int hi, input int base);
		apb_write(cso_pkg::REG_MIN_CHAR, cso_pkg::APB_DW'(lo));
		apb_write(cso_pkg::REG_MAX_CHAR, cso_pkg::APB_DW'(hi));
		apb_write(cso_pkg::REG_START_LEN, cso_pkg::APB_DW'(base));
		cfg_min  = cso_pkg::CHAR_W'(lo);
		cfg_max  = cso_pkg::CHAR_W'(hi);
		cfg_base = cso_pkg::BASE_W'(base);
		@(negedge clk);
	endtask

	task automatic set_pacing(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	// Returns at a falling edge once every item has gone and every character
	// has arrived, plus a short margin so that the block is truly idle.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_ch.valid || expected_chars.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	always @(negedge clk)
		all_settled <= !item_ch.valid && expected_chars.size() == 0;

	// Item driver.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				advance_string(cur_item);
				case (cur_item.kind)
					cso_pkg::KIND_START: n_start++;
					cso_pkg::KIND_NEXT:  n_next++;
					cso_pkg::KIND_SEEK:  n_seek++;
					default:             n_other++;
				endcase
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_items.size() != 0 && (!pending_items[0].hold || all_settled)
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					cur_item = pending_items.pop_front();
					item_ch.valid        <= 1'b1;
					item_ch.kind         <= cur_item.kind;
					item_ch.seek_address <= cur_item.address;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		char_beat_t exp_b;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_chars.size() == 0) begin
					$error("character transfer with nothing expected: char_code %0d",
						result_ch.char_code);
					errors++;
				end else begin
					exp_b = expected_chars.pop_front();
					check_field("char_code", exp_b.char_code, result_ch.char_code);
					check_field("position", exp_b.position, result_ch.position);
					check_field("length", exp_b.length, result_ch.length);
					check_field("overflow", exp_b.overflow, result_ch.overflow);
					check_field("last", exp_b.last, result_ch.last);
					if (exp_b.last && exp_b.overflow)
						ovf_strings++;
				end
				chars_checked++;
			end
			result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int p, n, r, lo, hi, base;
		int unsigned radix;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = '0;
		item_ch.seek_address = '0;
		result_ch.ready = 1'b0;
		errors = 0;
		n_start = 0;
		n_next = 0;
		n_seek = 0;
		n_other = 0;
		chars_checked = 0;
		ovf_strings = 0;
		quiet_cycles = 0;
		all_settled = 1'b0;
		set_pacing(0);
		cfg_min  = cso_pkg::RESET_MIN_CHAR;
		cfg_max  = cso_pkg::RESET_MAX_CHAR;
		cfg_base = cso_pkg::RESET_START_LEN;
		restart_string();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register values straight out of reset; one item waits for a full drain.
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		queue_item(cso_pkg::KIND_START, '0, 1'b0);
		queue_item(cso_pkg::KIND_SEEK, '0, 1'b0);
		queue_item(cso_pkg::KIND_SEEK, 64'd95, 1'b0);
		queue_item(cso_pkg::KIND_SEEK, 64'd9025, 1'b1);
		queue_item(cso_pkg::KIND_SEEK, '1, 1'b0);
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		queue_item(KIND_UNKNOWN, '1, 1'b0);
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		settle();

		// Full byte alphabet at the longest base length.
		set_pacing(1);
		program_alphabet(0, 255, 32);
		queue_item(cso_pkg::KIND_START, '0, 1'b0);
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		queue_item(cso_pkg::KIND_SEEK, '1, 1'b0);
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		settle();

		// Single-character alphabet: a nonzero seek must overflow; base of zero.
		set_pacing(2);
		program_alphabet(255, 255, 0);
		queue_item(cso_pkg::KIND_START, '0, 1'b0);
		queue_item(cso_pkg::KIND_SEEK, 64'd5, 1'b0);
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		queue_item(cso_pkg::KIND_START, '0, 1'b0);
		settle();

		// Inverted alphabet with an oversized base length wraps at full length.
		set_pacing(3);
		program_alphabet(20, 10, 63);
		queue_item(cso_pkg::KIND_START, '0, 1'b0);
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		settle();

		// Narrow the alphabet under an existing string so that characters fall
		// on both sides of it before the next step.
		set_pacing(0);
		program_alphabet(97, 122, 4);
		queue_item(cso_pkg::KIND_START, '0, 1'b0);
		queue_item(cso_pkg::KIND_SEEK, 64'd25, 1'b0);
		settle();
		program_alphabet(99, 121, 4);
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		queue_item(cso_pkg::KIND_NEXT, '0, 1'b0);
		settle();

		for (p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: begin lo = $urandom_range(0, 253); hi = lo + $urandom_range(1, 2); end
				1: begin lo = 97; hi = 122; end
				2: begin lo = $urandom_range(0, 255); hi = $urandom_range(lo, 255); end
				3: begin lo = 0; hi = 255; end
				4: begin lo = $urandom_range(1, 255); hi = $urandom_range(0, lo - 1); end
				default: begin lo = $urandom_range(0, 250); hi = lo + $urandom_range(0, 4); end
			endcase
			case ($urandom_range(0, 3))
				0: base = $urandom_range(5, 12);
				1: base = $urandom_range(0, 1) ? 0 : $urandom_range(32, 63);
				default: base = $urandom_range(1, 4);
			endcase
			radix = (hi < lo) ? 1 : hi - lo + 1;
			set_pacing(p);
			program_alphabet(lo, hi, base);
			queue_item(cso_pkg::KIND_START, '0, 1'b0);
			for (n = 1; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 58)
					queue_item(cso_pkg::KIND_NEXT, {$urandom, $urandom},
						$urandom_range(0, 19) == 0);
				else if (r < 83)
					queue_item(cso_pkg::KIND_SEEK, pick_address(radix),
						$urandom_range(0, 19) == 0);
				else if (r < 93)
					queue_item(cso_pkg::KIND_START, {$urandom, $urandom}, 1'b0);
				else
					queue_item(KIND_UNKNOWN, {$urandom, $urandom}, 1'b0);
			end
			settle();
		end

		repeat (40) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$error("%0d expected characters never arrived", expected_chars.size());
			errors++;
		end
		$display("Run covered %0d starts, %0d nexts, %0d seeks and %0d unknown kinds,",
			n_start, n_next, n_seek, n_other);
		$display("checking %0d character transfers; %0d strings carried the overflow flag.",
			chars_checked, ovf_strings);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
